### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

### design/eqwt_pkg.sv
// ----------------------------------------------------------------------------
// Tokenizer package
// Shared widths, character codes, register indexes and types.
// ----------------------------------------------------------------------------
package eqwt_pkg;

  localparam int unsigned CapacityW    = 13;
  localparam int unsigned BaseW        = 5;
  localparam int unsigned CharW        = 8;
  localparam int unsigned IndexW       = 12;
  localparam int unsigned CountW       = 13;
  localparam int unsigned LineW        = 16;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 13;
  localparam int unsigned DefMaxCapacity = 4096;

  localparam logic [CapacityW-1:0] CapacityReset = 13'd32;
  localparam logic [BaseW-1:0]     BaseReset     = 5'd10;
  localparam logic [CountW-1:0]    CountMax      = '1;

  // Register indexes on the write port
  localparam logic [CfgIdxW-1:0] RegWordCapacity = 1'd0;
  localparam logic [CfgIdxW-1:0] RegNumberBase   = 1'd1;

  // Character codes
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChLf    = 8'h0A;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChQuote = 8'h22;
  localparam logic [CharW-1:0] ChBslash = 8'h5C;
  localparam logic [CharW-1:0] ChLowerN = 8'h6E;

  typedef struct packed {
    logic              esc;
    logic              inq;
    logic [CountW-1:0] cnt;
    logic [ValueW-1:0] value;
    logic              bad;
    logic              ovf;
    logic [LineW-1:0]  line;
  } state_t;

  typedef struct packed {
    logic                  char_stored;
    logic [CharW-1:0]      stored_char;
    logic [IndexW-1:0]     stored_index;
    logic                  word_done;
    logic [CapacityW-1:0]  word_length;
    logic                  line_break;
    logic [LineW-1:0]      line_number;
    logic [ValueW-1:0]     number_value;
    logic                  number_bad;
    logic                  overflow;
    logic                  word_dropped;
  } result_t;

  // Hex digit decode: bit 4 is the valid flag, bits 3:0 the digit
  function automatic logic [4:0] hex_digit(input logic [CharW-1:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

### design/eqwt_step.sv
// ----------------------------------------------------------------------------
// Tokenizer step logic
// Next word state and result beat for one text byte.
// ----------------------------------------------------------------------------
module eqwt_step
  import eqwt_pkg::*;
#(
  parameter int unsigned MaxCapacity = DefMaxCapacity
) (
  input  state_t                cur_i,
  input  logic [CharW-1:0]      byte_i,
  input  logic                  last_i,
  input  logic [CapacityW-1:0]  capacity_i,
  input  logic [BaseW-1:0]      base_i,
  output state_t                nxt_o,
  output result_t               res_o
);

  localparam int unsigned MaxW = $clog2(MaxCapacity + 1);
  localparam int unsigned CmpW = (MaxW > CapacityW) ? MaxW : CapacityW;
  localparam logic [CmpW-1:0] MaxCap = CmpW'(MaxCapacity);

  logic [CmpW-1:0]   cap_wide;
  logic [CmpW-1:0]   cap_eff;
  logic              room;
  logic [4:0]        dig;
  logic [ValueW-1:0] mac;
  logic              app;
  logic              term;
  logic [CharW-1:0]  app_char;

  assign cap_wide = CmpW'(capacity_i);
  assign cap_eff  = (cap_wide > MaxCap) ? MaxCap : cap_wide;
  assign room     = CmpW'(cur_i.cnt) < cap_eff;
  // Escaped n turns into a newline; only used when a char is appended
  assign app_char = (cur_i.esc && byte_i == ChLowerN) ? ChLf : byte_i;
  assign dig      = hex_digit(app_char);
  assign mac      = cur_i.value * {{(ValueW-BaseW){1'b0}}, base_i}
                  + {{(ValueW-4){1'b0}}, dig[3:0]};

  always_comb begin
    nxt_o    = cur_i;
    res_o    = '0;
    app      = 1'b0;
    term     = 1'b0;

    if (byte_i == ChNul || byte_i == ChLf) begin
      // Line end wins over a pending escape
      nxt_o.esc         = 1'b0;
      nxt_o.line        = cur_i.line + 16'd1;
      res_o.line_break  = 1'b1;
      res_o.word_done   = 1'b1;
      res_o.word_length = cur_i.cnt;
      term              = 1'b1;
    end else if (cur_i.esc) begin
      nxt_o.esc = 1'b0;
      app       = 1'b1;
    end else if (byte_i == ChBslash) begin
      nxt_o.esc = 1'b1;
    end else if (byte_i == ChSpace) begin
      if (cur_i.inq) begin
        app = 1'b1;
      end else begin
        term = 1'b1;
        if (cur_i.cnt != '0) begin
          res_o.word_done   = 1'b1;
          res_o.word_length = cur_i.cnt;
        end
      end
    end else if (byte_i == ChQuote) begin
      nxt_o.inq = !cur_i.inq;
    end else begin
      app = 1'b1;
    end

    if (term && !room) begin
      nxt_o.ovf = 1'b1;
    end

    if (app) begin
      if (room) begin
        res_o.char_stored  = 1'b1;
        res_o.stored_char  = app_char;
        res_o.stored_index = cur_i.cnt[IndexW-1:0];
        if (dig[4]) begin
          nxt_o.value = mac;
        end else begin
          nxt_o.bad = 1'b1;
        end
      end else begin
        nxt_o.ovf = 1'b1;
      end
      if (cur_i.cnt != CountMax) begin
        nxt_o.cnt = cur_i.cnt + 13'd1;
      end
    end

    res_o.line_number  = nxt_o.line;
    res_o.number_value = nxt_o.value;
    res_o.number_bad   = nxt_o.bad;
    res_o.overflow     = nxt_o.ovf;
    res_o.word_dropped = !res_o.word_done && last_i && (nxt_o.cnt != '0);

    if (res_o.word_done) begin
      nxt_o.cnt   = '0;
      nxt_o.value = '0;
      nxt_o.bad   = 1'b0;
      nxt_o.ovf   = 1'b0;
    end
    if (last_i) begin
      nxt_o = '0;
    end
  end

endmodule

### design/escaped_quoted_word_tokenizer.sv
// ----------------------------------------------------------------------------
// Escaped, quoted word tokenizer
// Splits a byte stream into words, tracking length, numeric value and lines.
// ----------------------------------------------------------------------------
// One text byte is taken per beat and one result beat comes back for every
// byte, in order. The block takes a new byte every clock cycle unless the
// result channel stalls it; a byte goes from the input register through the
// step logic (one 32x5 multiply-add for the running number value) into the
// result register. The word state (escape, quote mode, count, value, flags,
// line count) is updated as a byte moves into the result register, so each
// byte sees the state left by the one before it. Write word_capacity and
// number_base only while no byte is in flight.

`include "assert_macros.svh"

module escaped_quoted_word_tokenizer
  import eqwt_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = DefMaxCapacity
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  // byte input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CharW-1:0]      byte_in_i,
  input  logic                  buffer_end_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  char_stored_o,
  output logic [CharW-1:0]      stored_char_o,
  output logic [IndexW-1:0]     stored_index_o,
  output logic                  word_done_o,
  output logic [CapacityW-1:0]  word_length_o,
  output logic                  line_break_o,
  output logic [LineW-1:0]      line_number_o,
  output logic [ValueW-1:0]     number_value_o,
  output logic                  number_bad_o,
  output logic                  overflow_o,
  output logic                  word_dropped_o
);

  // Configuration registers
  logic [CapacityW-1:0] capacity_q;
  logic [BaseW-1:0]     base_q;

  // Input register stage
  logic              in_valid_q, in_valid_d;
  logic [CharW-1:0]  byte_q;
  logic              last_q;

  // Word state and result register
  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    out_valid_q, out_valid_d;

  logic    in_accept;
  logic    advance;

  // Input beat moves on when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
      base_q     <= BaseReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWordCapacity: capacity_q <= cfg_wdata_i[CapacityW-1:0];
        RegNumberBase:   base_q     <= cfg_wdata_i[BaseW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= byte_in_i;
      last_q <= buffer_end_i;
    end
  end

  eqwt_step #(
    .MaxCapacity (MAX_CAPACITY)
  ) u_step (
    .cur_i      (state_q),
    .byte_i     (byte_q),
    .last_i     (last_q),
    .capacity_i (capacity_q),
    .base_i     (base_q),
    .nxt_o      (state_d),
    .res_o      (res_d)
  );

  // Word state only moves when its byte is committed to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign char_stored_o  = res_q.char_stored;
  assign stored_char_o  = res_q.stored_char;
  assign stored_index_o = res_q.stored_index;
  assign word_done_o    = res_q.word_done;
  assign word_length_o  = res_q.word_length;
  assign line_break_o   = res_q.line_break;
  assign line_number_o  = res_q.line_number;
  assign number_value_o = res_q.number_value;
  assign number_bad_o   = res_q.number_bad;
  assign overflow_o     = res_q.overflow;
  assign word_dropped_o = res_q.word_dropped;

  // An empty result register never pushes back on the input side
  `ASSERT_NEVER(a_no_stall_when_empty, clk_i, rst_ni, !out_valid_q && in_stall_o, "input stalled with empty result register")
  // A space only ends a word that has characters
  `ASSERT_NEVER(a_space_word_nonempty, clk_i, rst_ni, out_valid_q && res_q.word_done && !res_q.line_break && (res_q.word_length == '0), "empty word ended by a space")
  // A byte either appends or terminates, never both
  `ASSERT_NEVER(a_store_xor_done, clk_i, rst_ni, out_valid_q && res_q.char_stored && res_q.word_done, "character stored on a terminating byte")
  // A dropped word is never also a finished word
  `ASSERT_NEVER(a_drop_xor_done, clk_i, rst_ni, out_valid_q && res_q.word_dropped && res_q.word_done, "word both dropped and done")
  // A line break result always reports a finished word
  `ASSERT_PROP(a_break_implies_done, clk_i, rst_ni, (out_valid_q && res_q.line_break) |-> res_q.word_done, "line break without word end")

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Tokenizer testbench
// Streams text buffers through the word tokenizer and checks every result
// beat against an in-bench model of word, escape, quote and line handling.
// ----------------------------------------------------------------------------
// Flow: a short directed buffer at the reset settings, then random buffers
// under a series of capacity and base settings (register extremes included),
// then one long word that runs well past the word store. Both channels take
// random gaps and stalls, except for one phase that runs flat out. The model
// runs at input acceptance; its results queue up and the monitor pops them
// in order as result beats are taken.
module tb_top;
  import eqwt_pkg::*;

  // Character classes used by the stimulus and the model
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperF = 8'h46;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChLowerF = 8'h66;
  localparam logic [CharW-1:0] ChBang   = 8'h21;
  localparam logic [CharW-1:0] ChTilde  = 8'h7E;

  localparam int unsigned BusyPct    = 27;
  localparam int unsigned PhaseItems = 150;
  localparam int unsigned LongWord   = 80;
  localparam int unsigned LongCap    = 40;
  localparam int unsigned MaxReports = 200;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } text_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CharW-1:0] byte_in = '0;
  logic             buf_end = 1'b0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 char_stored;
  logic [CharW-1:0]     stored_char;
  logic [IndexW-1:0]    stored_index;
  logic                 word_done;
  logic [CapacityW-1:0] word_length;
  logic                 line_break;
  logic [LineW-1:0]     line_number;
  logic [ValueW-1:0]    number_value;
  logic                 number_bad;
  logic                 overflow;
  logic                 word_dropped;

  escaped_quoted_word_tokenizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .byte_in_i      (byte_in),
    .buffer_end_i   (buf_end),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .char_stored_o  (char_stored),
    .stored_char_o  (stored_char),
    .stored_index_o (stored_index),
    .word_done_o    (word_done),
    .word_length_o  (word_length),
    .line_break_o   (line_break),
    .line_number_o  (line_number),
    .number_value_o (number_value),
    .number_bad_o   (number_bad),
    .overflow_o     (overflow),
    .word_dropped_o (word_dropped)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tokenizer model: register copies and word state, reset values
  // --------------------------------------------------------------------------
  logic [CapacityW-1:0] cap_cfg  = CapacityReset;
  logic [BaseW-1:0]     base_cfg = BaseReset;

  logic              esc_r    = 1'b0;
  logic              quoted_r = 1'b0;
  logic [CountW-1:0] count_r  = '0;
  logic [ValueW-1:0] value_r  = '0;
  logic              bad_r    = 1'b0;
  logic              ovf_r    = 1'b0;
  logic [LineW-1:0]  line_r   = '0;

  text_beat_t text_beats[$];   // bytes waiting for the driver
  result_t    token_q[$];      // predicted result beats, oldest first
  logic [CharW-1:0] text_q[$]; // buffer under construction
  text_beat_t next_beat;

  int unsigned busy_pct = BusyPct;
  int unsigned err_count = 0;
  bit          failed = 1'b0;

  // Register above the hard store size saturates to it
  function automatic int unsigned store_size();
    return (cap_cfg > DefMaxCapacity) ? DefMaxCapacity : int'(cap_cfg);
  endfunction

  function automatic logic is_hex(input logic [CharW-1:0] ch, output logic [3:0] d);
    d = '0;
    if (ch >= ChZero && ch <= ChNine) begin
      d = 4'(ch - ChZero);
      return 1'b1;
    end
    if (ch >= ChUpperA && ch <= ChUpperF) begin
      d = 4'(ch - ChUpperA + 8'd10);
      return 1'b1;
    end
    if (ch >= ChLowerA && ch <= ChLowerF) begin
      d = 4'(ch - ChLowerA + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Append one char to the word. Past the store it is dropped but still
  // counted (count saturates), and it leaves the value alone.
  function automatic void add_char(input logic [CharW-1:0] ch, inout result_t r);
    logic [3:0] d;
    if (count_r < store_size()) begin
      r.char_stored  = 1'b1;
      r.stored_char  = ch;
      r.stored_index = count_r[IndexW-1:0];
      if (is_hex(ch, d)) begin
        value_r = value_r * ValueW'(base_cfg) + ValueW'(d);
      end else begin
        bad_r = 1'b1;
      end
    end else begin
      ovf_r = 1'b1;
    end
    if (count_r != CountMax) begin
      count_r = count_r + 1'b1;
    end
  endfunction

  function automatic result_t tok_step(input logic [CharW-1:0] ch, input logic last);
    result_t r;
    r = '0;
    if (ch == ChNul || ch == ChLf) begin
      // line end wins over a pending escape; quote mode survives it
      esc_r = 1'b0;
      line_r = line_r + 1'b1;
      if (count_r >= store_size()) begin
        ovf_r = 1'b1;
      end
      r.line_break  = 1'b1;
      r.word_done   = 1'b1;
      r.word_length = count_r;
    end else if (esc_r) begin
      esc_r = 1'b0;
      add_char((ch == ChLowerN) ? ChLf : ch, r);
    end else if (ch == ChBslash) begin
      esc_r = 1'b1;
    end else if (ch == ChSpace) begin
      if (quoted_r) begin
        add_char(ch, r);
      end else begin
        if (count_r >= store_size()) begin
          ovf_r = 1'b1;
        end
        // leading spaces give no word
        if (count_r != 0) begin
          r.word_done   = 1'b1;
          r.word_length = count_r;
        end
      end
    end else if (ch == ChQuote) begin
      quoted_r = !quoted_r;
    end else begin
      add_char(ch, r);
    end
    r.line_number  = line_r;
    r.number_value = value_r;
    r.number_bad   = bad_r;
    r.overflow     = ovf_r;
    r.word_dropped = !r.word_done && last && (count_r != 0);
    if (r.word_done || last) begin
      count_r = '0;
      value_r = '0;
      bad_r   = 1'b0;
      ovf_r   = 1'b0;
    end
    if (last) begin
      esc_r    = 1'b0;
      quoted_r = 1'b0;
      line_r   = '0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: takes bytes from text_beats, runs the model on each accepted beat
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      byte_in  <= '0;
      buf_end  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        token_q.push_back(tok_step(byte_in, buf_end));
      end
      // held beat stays put until taken
      if (!in_valid || !in_stall) begin
        if (text_beats.size() != 0 && $urandom_range(99) >= busy_pct) begin
          next_beat = text_beats.pop_front();
          in_valid <= 1'b1;
          byte_in  <= next_beat.ch;
          buf_end  <= next_beat.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random stall, field-by-field compare against the oldest entry
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      failed = 1'b1;
      err_count++;
      if (err_count <= MaxReports) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          failed = 1'b1;
          err_count++;
          if (err_count <= MaxReports) begin
            $display("%0t: result beat with none expected: expected none, actual %0h",
                     $time, stored_char);
          end
        end else begin
          check_field("char_stored",  32'(token_q[0].char_stored),  32'(char_stored));
          check_field("stored_char",  32'(token_q[0].stored_char),  32'(stored_char));
          check_field("stored_index", 32'(token_q[0].stored_index), 32'(stored_index));
          check_field("word_done",    32'(token_q[0].word_done),    32'(word_done));
          check_field("word_length",  32'(token_q[0].word_length),  32'(word_length));
          check_field("line_break",   32'(token_q[0].line_break),   32'(line_break));
          check_field("line_number",  32'(token_q[0].line_number),  32'(line_number));
          check_field("number_value", token_q[0].number_value,      number_value);
          check_field("number_bad",   32'(token_q[0].number_bad),   32'(number_bad));
          check_field("overflow",     32'(token_q[0].overflow),     32'(overflow));
          check_field("word_dropped", 32'(token_q[0].word_dropped), 32'(word_dropped));
          void'(token_q.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < busy_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_beat(input logic [CharW-1:0] ch, input logic last);
    text_beats.push_back('{ch: ch, last: last});
  endtask

  // Every byte accepted and every result back
  task automatic wait_drained();
    while (text_beats.size() != 0 || in_valid || token_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CfgDataW'(val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == RegWordCapacity) begin
      cap_cfg = CapacityW'(val);
    end else begin
      base_cfg = BaseW'(val);
    end
  endtask

  function automatic logic [CharW-1:0] hex_char();
    case ($urandom_range(2))
      0:       return ChZero + 8'($urandom_range(9));
      1:       return ChUpperA + 8'($urandom_range(5));
      default: return ChLowerA + 8'($urandom_range(5));
    endcase
  endfunction

  // Word body: mostly digits, some printable text, escapes, quotes, raw noise
  task automatic add_word(input int unsigned len);
    int unsigned r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        text_q.push_back(ChBslash);
        text_q.push_back(($urandom_range(1) == 0) ? ChLowerN : 8'($urandom_range(255)));
      end else if (r < 14) begin
        text_q.push_back(ChQuote);
      end else if (r < 60) begin
        text_q.push_back(hex_char());
      end else if (r < 88) begin
        text_q.push_back(8'($urandom_range(ChTilde, ChBang)));
      end else begin
        text_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic add_separator();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) begin
      repeat ($urandom_range(3, 1)) text_q.push_back(ChSpace);
    end else if (r < 80) begin
      text_q.push_back(ChLf);
    end else if (r < 90) begin
      text_q.push_back(ChNul);
    end else begin
      text_q.push_back(ChLf);
      text_q.push_back(ChLf);
    end
  endtask

  // One buffer of words; buffer_end rides on its last byte. About one in ten
  // is raw noise, and some stop mid-word so the pending word gets dropped.
  task automatic queue_buffer();
    int unsigned nwords;
    int unsigned hi;
    text_q.delete();
    hi = (cap_cfg + 3 > 40) ? 40 : cap_cfg + 3;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(20, 1)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      nwords = $urandom_range(5, 1);
      repeat ($urandom_range(2)) text_q.push_back(ChSpace);
      for (int w = 0; w < nwords; w++) begin
        add_word(($urandom_range(99) < 80) ? $urandom_range(8, 1) : $urandom_range(hi, 1));
        if (w + 1 < nwords || $urandom_range(99) < 60) begin
          add_separator();
        end
      end
    end
    foreach (text_q[i]) begin
      push_beat(text_q[i], i == text_q.size() - 1);
    end
  endtask

  task automatic random_phase(input int unsigned cap, input int unsigned base,
                              input bit calm);
    int unsigned queued;
    wait_drained();
    write_reg(RegWordCapacity, cap);
    write_reg(RegNumberBase, base);
    busy_pct = calm ? 0 : BusyPct;
    queued = 0;
    while (queued < PhaseItems) begin
      queue_buffer();
      queued += text_q.size();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed buffer at reset settings (capacity 32, base 10)
    push_beat(ChSpace, 1'b0);          // leading spaces skipped
    push_beat(ChSpace, 1'b0);
    push_beat(ChNine, 1'b0);
    push_beat(ChUpperF, 1'b0);
    push_beat(ChLowerF, 1'b0);
    push_beat(ChSpace, 1'b0);          // ends the word
    push_beat(ChBslash, 1'b0);         // escaped n stores a newline
    push_beat(ChLowerN, 1'b0);
    push_beat(ChBslash, 1'b0);         // escape before newline: line still ends
    push_beat(ChLf, 1'b0);
    push_beat(ChQuote, 1'b0);          // quoted space is part of the word
    push_beat(ChLowerA, 1'b0);
    push_beat(ChSpace, 1'b0);
    push_beat(ChQuote, 1'b0);
    push_beat(ChSpace, 1'b0);
    push_beat(ChQuote, 1'b0);          // quote mode held across a NUL line end
    push_beat(ChNul, 1'b0);
    push_beat(ChZero, 1'b0);
    push_beat(ChSpace, 1'b0);
    push_beat(ChBslash, 1'b0);         // escaped backslash
    push_beat(ChBslash, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h80, 1'b1);            // buffer end mid-word: dropped, all cleared
    push_beat(ChSpace, 1'b1);          // buffer end with nothing pending

    // Random buffers over capacity/base settings; first phase without gaps
    random_phase(8, 16, 1'b1);
    random_phase(1, 2, 1'b0);
    random_phase(0, 10, 1'b0);         // every char and terminator overflows
    random_phase(3, 0, 1'b0);          // base zero used as given
    random_phase(5, 31, 1'b0);
    random_phase(4096, 16, 1'b0);
    random_phase(12, 1, 1'b0);
    random_phase(8191, 8, 1'b0);       // register above the store size
    random_phase(33, 10, 1'b0);

    // One long word: runs well past the word store, tail chars dropped
    wait_drained();
    write_reg(RegWordCapacity, LongCap);
    write_reg(RegNumberBase, 16);
    busy_pct = BusyPct;
    for (int i = 0; i < LongWord; i++) begin
      push_beat(($urandom_range(99) < 95) ? hex_char() : 8'($urandom_range(ChTilde, 8'h67)),
                1'b0);
    end
    push_beat(ChSpace, 1'b1);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (!failed && token_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
